[design/multi_cost_shortest_path_top_defines.svh]
// assertion macros for the multi-cost shortest path block
// no dependencies; included by the files that carry assertions
`ifndef MULTI_COST_SHORTEST_PATH_TOP_DEFINES_SVH
`define MULTI_COST_SHORTEST_PATH_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MCSP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcsp assertion failed");
`define MCSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcsp assertion failed");
`else
`define MCSP_ASSERT_SAME(label, ante, cons)
`define MCSP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/mcsp_pkg.sv]
// shared types and constants of the multi-cost shortest path block
// no dependencies
package mcsp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VID_W        = 10;
  localparam int CNT_W        = 11;
  localparam int EID_W        = 12;
  localparam int ELNK_W       = 13;
  localparam int COST_W       = 16;
  localparam int DIST_W       = 32;
  localparam int VEH_W        = 2;
  localparam logic [DIST_W-1:0] INF_DIST = '1;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_SOLVE = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [ELNK_W-1:0]            nxt;
    logic [VID_W-1:0]             target;
    logic [3:0][COST_W-1:0]       cost;
  } edge_rec_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_GCLR, ST_ADD_RD, ST_Q_RD, ST_INIT,
    ST_SU_CHK, ST_SU_SLOT, ST_SU_KEY,
    ST_EX0, ST_EX1, ST_EX2, ST_EX3,
    ST_SD_CHK, ST_SD_LS, ST_SD_LK, ST_SD_RS, ST_SD_RK, ST_SD_DEC, ST_SD_FIN,
    ST_EH, ST_ED_CHK, ST_ED_RD, ST_ED_PL, ST_ED_DST,
    ST_CP_RD, ST_CP_WR
  } state_t;

endpackage

[design/mcsp_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module mcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/multi_cost_shortest_path_top.sv]
// multi-cost shortest path engine: edge lists, heap-based solver, result store
// solve: sets up and copies out each vertex, moves the hole level by level through the heap
//   and scans each edge of a reached vertex; each step waits on the registered ram reads
// one item at a time: busy, when raised, stays high until the result strobe; results cannot be stalled
// reset: synchronous active low, then a clearing pass over lists and results
`include "multi_cost_shortest_path_top_defines.svh"
module multi_cost_shortest_path_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [9:0]  in_from_vertex,
  input  logic [9:0]  in_to_vertex,
  input  logic [1:0]  in_vehicle,
  input  logic [15:0] in_walk_cost,
  input  logic [15:0] in_car_cost,
  input  logic [15:0] in_bike_cost,
  input  logic [15:0] in_terrain_cost,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [9:0]  out_vertex,
  output logic [31:0] out_distance,
  output logic [9:0]  out_predecessor,
  output logic        out_reached,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_vertex_count
);

  localparam int VW = mcsp_pkg::VID_W;
  localparam int CW = mcsp_pkg::CNT_W;
  localparam int EW = mcsp_pkg::EID_W;
  localparam int LW = mcsp_pkg::ELNK_W;
  localparam int DW = mcsp_pkg::DIST_W;
  localparam int RW = mcsp_pkg::VEH_W + VW;
  localparam logic [CW-1:0] NMAX = CW'(mcsp_pkg::MAX_VERTICES);
  localparam logic [LW-1:0] EMAX = LW'(mcsp_pkg::MAX_EDGES);

  // control state
  mcsp_pkg::state_t state_r, state_nxt;
  logic [EW-1:0] idx_r, idx_nxt;          // sweep counter
  logic [LW-1:0] total_r, total_nxt;      // edges stored
  logic [CW-1:0] fill_r, fill_nxt;        // heap fill
  logic [CW-1:0] vcount_r;                // configured vertex count
  logic          out_valid_r, out_valid_nxt;

  // item and working registers
  logic [VW-1:0] src_r, src_nxt;
  logic [VW-1:0] to_r, to_nxt;
  logic [1:0]    veh_r, veh_nxt;
  logic [63:0]   costs_r, costs_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [VW-1:0] pos_r, pos_nxt;          // heap hole position
  logic [VW-1:0] x_r, x_nxt;              // vertex being sifted
  logic [DW-1:0] k_r, k_nxt;              // its key
  logic [VW-1:0] m_r, m_nxt;              // parent or chosen child slot
  logic [VW-1:0] vm_r, vm_nxt;            // vertex at that slot
  logic [VW-1:0] vr_r, vr_nxt;            // right child vertex
  logic [DW-1:0] km_r, km_nxt;            // smallest key seen in sift-down
  logic          moved_r, moved_nxt;
  logic          su_relax_r, su_relax_nxt; // sift-up came from a relaxation
  logic [VW-1:0] u_r, u_nxt;
  logic [DW-1:0] du_r, du_nxt;
  logic [LW-1:0] e_r, e_nxt;
  logic [LW-1:0] next_r, next_nxt;
  logic [VW-1:0] t_r, t_nxt;
  logic [15:0]   cost_r, cost_nxt;
  logic [DW-1:0] sum_r, sum_nxt;

  // result word
  logic [1:0]    o_status_r, o_status_nxt;
  logic [VW-1:0] o_vertex_r, o_vertex_nxt;
  logic [DW-1:0] o_dist_r, o_dist_nxt;
  logic [VW-1:0] o_pred_r, o_pred_nxt;
  logic          o_reached_r, o_reached_nxt;

  // memory ports
  logic          head_we;
  logic [VW-1:0] head_wa, head_ra;
  logic [LW-1:0] head_wd, head_rd;
  logic          edge_we;
  logic [EW-1:0] edge_wa, edge_ra;
  mcsp_pkg::edge_rec_t edge_wd, edge_rd;
  logic          dist_we;
  logic [VW-1:0] dist_wa, dist_ra;
  logic [DW-1:0] dist_wd, dist_rd;
  logic          slot_we;
  logic [VW-1:0] slot_wa, slot_ra, slot_wd, slot_rd;
  logic          place_we;
  logic [VW-1:0] place_wa, place_ra, place_wd, place_rd;
  logic          bprev_we;
  logic [RW-1:0] bprev_wa, bprev_ra;
  logic [VW-1:0] bprev_wd, bprev_rd;
  logic          bcost_we;
  logic [RW-1:0] bcost_wa, bcost_ra;
  logic [DW-1:0] bcost_wd, bcost_rd;

  // per-vertex list heads, edge records, and the solver's heap state
  mcsp_ram #(.WIDTH(LW), .DEPTH(mcsp_pkg::MAX_VERTICES)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
  mcsp_ram #(.WIDTH($bits(mcsp_pkg::edge_rec_t)), .DEPTH(mcsp_pkg::MAX_EDGES)) u_edge (
    .clk, .we(edge_we), .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd));
  mcsp_ram #(.WIDTH(DW), .DEPTH(mcsp_pkg::MAX_VERTICES)) u_dist (
    .clk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra), .rdata(dist_rd));
  mcsp_ram #(.WIDTH(VW), .DEPTH(mcsp_pkg::MAX_VERTICES)) u_slot (
    .clk, .we(slot_we), .waddr(slot_wa), .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_rd));
  mcsp_ram #(.WIDTH(VW), .DEPTH(mcsp_pkg::MAX_VERTICES)) u_place (
    .clk, .we(place_we), .waddr(place_wa), .wdata(place_wd), .raddr(place_ra),
    .rdata(place_rd));
  // stored results, indexed by {vehicle, vertex}
  mcsp_ram #(.WIDTH(VW), .DEPTH(mcsp_pkg::MAX_EDGES)) u_bprev (
    .clk, .we(bprev_we), .waddr(bprev_wa), .wdata(bprev_wd), .raddr(bprev_ra),
    .rdata(bprev_rd));
  mcsp_ram #(.WIDTH(DW), .DEPTH(mcsp_pkg::MAX_EDGES)) u_bcost (
    .clk, .we(bcost_we), .waddr(bcost_wa), .wdata(bcost_wd), .raddr(bcost_ra),
    .rdata(bcost_rd));

  assign busy            = (state_r != mcsp_pkg::ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_vertex      = o_vertex_r;
  assign out_distance    = o_dist_r;
  assign out_predecessor = o_pred_r;
  assign out_reached     = o_reached_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcsp_pkg::ST_CLR;
      idx_r       <= '0;
      total_r     <= '0;
      fill_r      <= '0;
      vcount_r    <= NMAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_vertex_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;   to_r <= to_nxt;     veh_r <= veh_nxt;
    costs_r <= costs_nxt; n_r <= n_nxt;     pos_r <= pos_nxt;   x_r <= x_nxt;
    k_r <= k_nxt;       m_r <= m_nxt;       vm_r <= vm_nxt;     vr_r <= vr_nxt;
    km_r <= km_nxt;     moved_r <= moved_nxt; su_relax_r <= su_relax_nxt;
    u_r <= u_nxt;       du_r <= du_nxt;     e_r <= e_nxt;       next_r <= next_nxt;
    t_r <= t_nxt;       cost_r <= cost_nxt; sum_r <= sum_nxt;
    o_status_r <= o_status_nxt; o_vertex_r <= o_vertex_nxt; o_dist_r <= o_dist_nxt;
    o_pred_r <= o_pred_nxt;     o_reached_r <= o_reached_nxt;
  end

  always_comb begin
    logic [CW-1:0] n_new;
    logic [CW-1:0] fill_m1;
    logic [EW-1:0] lchild;
    logic [EW-1:0] rchild;
    logic [DW:0]   sum_wide;

    state_nxt = state_r;  idx_nxt = idx_r;   total_nxt = total_r; fill_nxt = fill_r;
    out_valid_nxt = 1'b0;
    src_nxt = src_r;  to_nxt = to_r;  veh_nxt = veh_r;
    costs_nxt = costs_r;  n_nxt = n_r;  pos_nxt = pos_r;  x_nxt = x_r;  k_nxt = k_r;
    m_nxt = m_r;  vm_nxt = vm_r;  vr_nxt = vr_r;  km_nxt = km_r;  moved_nxt = moved_r;
    su_relax_nxt = su_relax_r;  u_nxt = u_r;  du_nxt = du_r;  e_nxt = e_r;
    next_nxt = next_r;  t_nxt = t_r;  cost_nxt = cost_r;  sum_nxt = sum_r;
    o_status_nxt = o_status_r;  o_vertex_nxt = o_vertex_r;  o_dist_nxt = o_dist_r;
    o_pred_nxt = o_pred_r;  o_reached_nxt = o_reached_r;

    head_we = 1'b0;  head_wa = '0;  head_wd = '0;  head_ra = '0;
    edge_we = 1'b0;  edge_wa = '0;  edge_wd = '0;  edge_ra = '0;
    dist_we = 1'b0;  dist_wa = '0;  dist_wd = '0;  dist_ra = '0;
    slot_we = 1'b0;  slot_wa = '0;  slot_wd = '0;  slot_ra = '0;
    place_we = 1'b0; place_wa = '0; place_wd = '0; place_ra = '0;
    bprev_we = 1'b0; bprev_wa = '0; bprev_wd = '0; bprev_ra = '0;
    bcost_we = 1'b0; bcost_wa = '0; bcost_wd = '0; bcost_ra = '0;

    n_new    = (vcount_r > NMAX) ? NMAX : vcount_r;
    fill_m1  = fill_r - CW'(1);
    lchild   = {1'b0, pos_r, 1'b1};
    rchild   = lchild + EW'(1);
    sum_wide = {1'b0, du_r} + (DW+1)'(cost_r);

    unique case (state_r)
      // reset sweep: empty every list and zero every stored result
      mcsp_pkg::ST_CLR: begin
        head_we  = (idx_r[EW-1:VW] == '0);
        head_wa  = idx_r[VW-1:0];
        bprev_we = 1'b1;
        bprev_wa = idx_r;
        bcost_we = 1'b1;
        bcost_wa = idx_r;
        idx_nxt  = idx_r + EW'(1);
        if (&idx_r) begin
          state_nxt = mcsp_pkg::ST_IDLE;
        end
      end

      mcsp_pkg::ST_IDLE: begin
        if (start) begin
          src_nxt   = in_from_vertex;
          to_nxt    = in_to_vertex;
          veh_nxt   = in_vehicle;
          costs_nxt = {in_terrain_cost, in_bike_cost, in_car_cost, in_walk_cost};
          n_nxt     = n_new;
          idx_nxt   = '0;
          o_vertex_nxt  = in_from_vertex;
          o_dist_nxt    = '0;
          o_pred_nxt    = '0;
          o_reached_nxt = 1'b0;
          o_status_nxt  = mcsp_pkg::STAT_OK;
          unique case (mcsp_pkg::action_t'(in_action))
            mcsp_pkg::ACT_ADD: begin
              // vertex ids are 10 bits, so they are always in range here
              if (total_r == EMAX) begin
                o_status_nxt  = mcsp_pkg::STAT_FULL;
                out_valid_nxt = 1'b1;
              end else begin
                head_ra   = in_from_vertex;
                state_nxt = mcsp_pkg::ST_ADD_RD;
              end
            end
            mcsp_pkg::ACT_SOLVE: begin
              if ({1'b0, in_from_vertex} >= n_new) begin
                o_status_nxt  = mcsp_pkg::STAT_RANGE;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = mcsp_pkg::ST_INIT;
              end
            end
            mcsp_pkg::ACT_QUERY: begin
              if ({1'b0, in_from_vertex} >= n_new) begin
                o_status_nxt  = mcsp_pkg::STAT_RANGE;
                out_valid_nxt = 1'b1;
              end else begin
                bprev_ra  = {in_vehicle, in_from_vertex};
                bcost_ra  = {in_vehicle, in_from_vertex};
                state_nxt = mcsp_pkg::ST_Q_RD;
              end
            end
            mcsp_pkg::ACT_CLEAR: begin
              state_nxt = mcsp_pkg::ST_GCLR;
            end
          endcase
        end
      end

      // clear graph: sweep the list heads, results stay
      mcsp_pkg::ST_GCLR: begin
        head_we = 1'b1;
        head_wa = idx_r[VW-1:0];
        idx_nxt = idx_r + EW'(1);
        if (&idx_r[VW-1:0]) begin
          total_nxt     = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = mcsp_pkg::ST_IDLE;
        end
      end

      // new edge goes at the head of its source's list
      mcsp_pkg::ST_ADD_RD: begin
        edge_we        = 1'b1;
        edge_wa        = total_r[EW-1:0];
        edge_wd.nxt    = head_rd;
        edge_wd.target = to_r;
        edge_wd.cost   = costs_r;
        head_we        = 1'b1;
        head_wa        = src_r;
        head_wd        = total_r + LW'(1);
        total_nxt      = total_r + LW'(1);
        out_valid_nxt  = 1'b1;
        state_nxt      = mcsp_pkg::ST_IDLE;
      end

      mcsp_pkg::ST_Q_RD: begin
        o_dist_nxt    = bcost_rd;
        o_pred_nxt    = bprev_rd;
        o_reached_nxt = (bcost_rd != mcsp_pkg::INF_DIST);
        out_valid_nxt = 1'b1;
        state_nxt     = mcsp_pkg::ST_IDLE;
      end

      // heap in vertex order, all keys infinite but the source
      mcsp_pkg::ST_INIT: begin
        dist_we  = 1'b1;
        dist_wa  = idx_r[VW-1:0];
        dist_wd  = (idx_r[VW-1:0] == src_r) ? '0 : mcsp_pkg::INF_DIST;
        slot_we  = 1'b1;
        slot_wa  = idx_r[VW-1:0];
        slot_wd  = idx_r[VW-1:0];
        place_we = 1'b1;
        place_wa = idx_r[VW-1:0];
        place_wd = idx_r[VW-1:0];
        idx_nxt  = idx_r + EW'(1);
        if (idx_r[CW-1:0] == n_r - CW'(1)) begin
          fill_nxt     = n_r;
          pos_nxt      = src_r;
          x_nxt        = src_r;
          k_nxt        = '0;
          su_relax_nxt = 1'b0;
          state_nxt    = mcsp_pkg::ST_SU_CHK;
        end
      end

      // sift-up with a moving hole; parents move down on strictly larger keys
      mcsp_pkg::ST_SU_CHK: begin
        if (pos_r == '0) begin
          slot_we  = 1'b1;
          slot_wa  = '0;
          slot_wd  = x_r;
          place_we = 1'b1;
          place_wa = x_r;
          place_wd = '0;
          e_nxt    = next_r;
          state_nxt = su_relax_r ? mcsp_pkg::ST_ED_CHK : mcsp_pkg::ST_EX0;
        end else begin
          m_nxt     = (pos_r - VW'(1)) >> 1;
          slot_ra   = (pos_r - VW'(1)) >> 1;
          state_nxt = mcsp_pkg::ST_SU_SLOT;
        end
      end

      mcsp_pkg::ST_SU_SLOT: begin
        vm_nxt    = slot_rd;
        dist_ra   = slot_rd;
        state_nxt = mcsp_pkg::ST_SU_KEY;
      end

      mcsp_pkg::ST_SU_KEY: begin
        slot_we  = 1'b1;
        slot_wa  = pos_r;
        place_we = 1'b1;
        place_wd = pos_r;
        if (k_r < dist_rd) begin
          slot_wd   = vm_r;
          place_wa  = vm_r;
          pos_nxt   = m_r;
          state_nxt = mcsp_pkg::ST_SU_CHK;
        end else begin
          slot_wd   = x_r;
          place_wa  = x_r;
          e_nxt     = next_r;
          state_nxt = su_relax_r ? mcsp_pkg::ST_ED_CHK : mcsp_pkg::ST_EX0;
        end
      end

      // extract the minimum
      mcsp_pkg::ST_EX0: begin
        slot_ra = '0;
        if (fill_r == '0) begin
          idx_nxt   = '0;
          state_nxt = mcsp_pkg::ST_CP_RD;
        end else begin
          state_nxt = mcsp_pkg::ST_EX1;
        end
      end

      mcsp_pkg::ST_EX1: begin
        u_nxt     = slot_rd;
        dist_ra   = slot_rd;
        slot_ra   = fill_m1[VW-1:0];
        state_nxt = mcsp_pkg::ST_EX2;
      end

      // last slot's vertex becomes the hole filler at the root
      mcsp_pkg::ST_EX2: begin
        du_nxt    = dist_rd;
        x_nxt     = slot_rd;
        dist_ra   = slot_rd;
        place_we  = 1'b1;
        place_wa  = u_r;
        place_wd  = fill_m1[VW-1:0];
        fill_nxt  = fill_m1;
        state_nxt = mcsp_pkg::ST_EX3;
      end

      mcsp_pkg::ST_EX3: begin
        k_nxt     = dist_rd;
        pos_nxt   = '0;
        state_nxt = mcsp_pkg::ST_SD_CHK;
      end

      // sift-down: strictly smaller child wins, left before right on ties
      mcsp_pkg::ST_SD_CHK: begin
        moved_nxt = 1'b0;
        if (lchild < EW'(fill_r)) begin
          slot_ra   = lchild[VW-1:0];
          state_nxt = mcsp_pkg::ST_SD_LS;
        end else begin
          state_nxt = mcsp_pkg::ST_SD_FIN;
        end
      end

      mcsp_pkg::ST_SD_LS: begin
        vm_nxt    = slot_rd;
        dist_ra   = slot_rd;
        state_nxt = mcsp_pkg::ST_SD_LK;
      end

      mcsp_pkg::ST_SD_LK: begin
        if (dist_rd < k_r) begin
          moved_nxt = 1'b1;
          m_nxt     = lchild[VW-1:0];
          km_nxt    = dist_rd;
        end else begin
          km_nxt    = k_r;
        end
        if (rchild < EW'(fill_r)) begin
          slot_ra   = rchild[VW-1:0];
          state_nxt = mcsp_pkg::ST_SD_RS;
        end else begin
          state_nxt = mcsp_pkg::ST_SD_DEC;
        end
      end

      mcsp_pkg::ST_SD_RS: begin
        vr_nxt    = slot_rd;
        dist_ra   = slot_rd;
        state_nxt = mcsp_pkg::ST_SD_RK;
      end

      mcsp_pkg::ST_SD_RK: begin
        if (dist_rd < km_r) begin
          moved_nxt = 1'b1;
          m_nxt     = rchild[VW-1:0];
          vm_nxt    = vr_r;
        end
        state_nxt = mcsp_pkg::ST_SD_DEC;
      end

      mcsp_pkg::ST_SD_DEC: begin
        if (moved_r) begin
          slot_we   = 1'b1;
          slot_wa   = pos_r;
          slot_wd   = vm_r;
          place_we  = 1'b1;
          place_wa  = vm_r;
          place_wd  = pos_r;
          pos_nxt   = m_r;
          state_nxt = mcsp_pkg::ST_SD_CHK;
        end else begin
          state_nxt = mcsp_pkg::ST_SD_FIN;
        end
      end

      // hole settles; unreached vertices relax nothing
      mcsp_pkg::ST_SD_FIN: begin
        slot_we  = 1'b1;
        slot_wa  = pos_r;
        slot_wd  = x_r;
        place_we = 1'b1;
        place_wa = x_r;
        place_wd = pos_r;
        head_ra  = u_r;
        state_nxt = (du_r == mcsp_pkg::INF_DIST) ? mcsp_pkg::ST_EX0 : mcsp_pkg::ST_EH;
      end

      mcsp_pkg::ST_EH: begin
        e_nxt     = head_rd;
        state_nxt = mcsp_pkg::ST_ED_CHK;
      end

      // walk the edge list of u
      mcsp_pkg::ST_ED_CHK: begin
        if (e_r == '0) begin
          state_nxt = mcsp_pkg::ST_EX0;
        end else begin
          edge_ra   = EW'(e_r - LW'(1));
          state_nxt = mcsp_pkg::ST_ED_RD;
        end
      end

      mcsp_pkg::ST_ED_RD: begin
        t_nxt    = edge_rd.target;
        next_nxt = edge_rd.nxt;
        cost_nxt = edge_rd.cost[veh_r];
        place_ra = edge_rd.target;
        if ({1'b0, edge_rd.target} < n_r) begin
          state_nxt = mcsp_pkg::ST_ED_PL;
        end else begin
          e_nxt     = edge_rd.nxt;
          state_nxt = mcsp_pkg::ST_ED_CHK;
        end
      end

      // target still in the heap: form the saturated sum
      mcsp_pkg::ST_ED_PL: begin
        if ({1'b0, place_rd} < fill_r) begin
          pos_nxt   = place_rd;
          sum_nxt   = (sum_wide >= {1'b0, mcsp_pkg::INF_DIST}) ? mcsp_pkg::INF_DIST
                                                               : sum_wide[DW-1:0];
          dist_ra   = t_r;
          state_nxt = mcsp_pkg::ST_ED_DST;
        end else begin
          e_nxt     = next_r;
          state_nxt = mcsp_pkg::ST_ED_CHK;
        end
      end

      mcsp_pkg::ST_ED_DST: begin
        if (sum_r < dist_rd) begin
          dist_we      = 1'b1;
          dist_wa      = t_r;
          dist_wd      = sum_r;
          bprev_we     = 1'b1;
          bprev_wa     = {veh_r, t_r};
          bprev_wd     = u_r;
          x_nxt        = t_r;
          k_nxt        = sum_r;
          su_relax_nxt = 1'b1;
          state_nxt    = mcsp_pkg::ST_SU_CHK;
        end else begin
          e_nxt     = next_r;
          state_nxt = mcsp_pkg::ST_ED_CHK;
        end
      end

      // copy final distances into the result store
      mcsp_pkg::ST_CP_RD: begin
        dist_ra   = idx_r[VW-1:0];
        state_nxt = mcsp_pkg::ST_CP_WR;
      end

      mcsp_pkg::ST_CP_WR: begin
        bcost_we = 1'b1;
        bcost_wa = {veh_r, idx_r[VW-1:0]};
        bcost_wd = dist_rd;
        idx_nxt  = idx_r + EW'(1);
        if (idx_r[CW-1:0] == n_r - CW'(1)) begin
          o_reached_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mcsp_pkg::ST_IDLE;
        end else begin
          state_nxt = mcsp_pkg::ST_CP_RD;
        end
      end

      default: begin
        state_nxt = mcsp_pkg::ST_IDLE;
      end
    endcase
  end

  // an accepted item either answers next cycle or keeps the block busy
  `MCSP_ASSERT_NEXT(a_item_progress, start && !busy, out_valid_r || busy)
  // the heap never holds more than the vertex count of the solve
  `MCSP_ASSERT_SAME(a_fill_bound, state_r != mcsp_pkg::ST_CLR, fill_r <= n_r || fill_r == '0)
  // edge count never passes the store size
  `MCSP_ASSERT_SAME(a_total_bound, 1'b1, total_r <= EMAX)
  // a reached word is always an ok word
  `MCSP_ASSERT_SAME(a_reached_ok, out_valid_r && o_reached_r, o_status_r == mcsp_pkg::STAT_OK)

endmodule

[sim/tb_multi_cost_shortest_path_top.sv]
// testbench for multi_cost_shortest_path_top: directed and random words, with a
// self-contained Dijkstra predictor checked against every result; needs mcsp_pkg
`timescale 1ns / 100ps
module tb_multi_cost_shortest_path_top;

  // one result word as seen on the out_ ports
  typedef struct {
    mcsp_pkg::status_t status;
    logic [9:0]   vertex;
    logic [31:0]  distance;
    logic [9:0]   predecessor;
    logic         reached;
  } path_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [9:0]  in_from_vertex;
  logic [9:0]  in_to_vertex;
  logic [1:0]  in_vehicle;
  logic [15:0] in_walk_cost;
  logic [15:0] in_car_cost;
  logic [15:0] in_bike_cost;
  logic [15:0] in_terrain_cost;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [9:0]  out_vertex;
  logic [31:0] out_distance;
  logic [9:0]  out_predecessor;
  logic        out_reached;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_vertex_count;

  multi_cost_shortest_path_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_from_vertex(in_from_vertex),
    .in_to_vertex(in_to_vertex), .in_vehicle(in_vehicle),
    .in_walk_cost(in_walk_cost), .in_car_cost(in_car_cost),
    .in_bike_cost(in_bike_cost), .in_terrain_cost(in_terrain_cost),
    .out_valid(out_valid), .out_status(out_status), .out_vertex(out_vertex),
    .out_distance(out_distance), .out_predecessor(out_predecessor),
    .out_reached(out_reached), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_vertex_count(cfg_vertex_count)
  );

  // model state of the graph, the solver and the stored solutions
  int unsigned  list_first [mcsp_pkg::MAX_VERTICES];    // edge index + 1, 0 = empty list
  int unsigned  link_next  [mcsp_pkg::MAX_EDGES];
  logic [9:0]   link_target[mcsp_pkg::MAX_EDGES];
  logic [15:0]  link_cost  [mcsp_pkg::MAX_EDGES][4];
  int unsigned  edges_stored;
  logic [31:0]  tentative  [mcsp_pkg::MAX_VERTICES];
  int unsigned  heap_vertex[mcsp_pkg::MAX_VERTICES];
  int unsigned  heap_index [mcsp_pkg::MAX_VERTICES];
  int unsigned  heap_size;
  logic [9:0]   route_prev [4*mcsp_pkg::MAX_VERTICES];
  logic [31:0]  route_cost [4*mcsp_pkg::MAX_VERTICES];
  int unsigned  vertices_used;

  path_result_t expected_results[$];
  int           err_count;
  int           words_sent;
  int           words_checked;
  int           solves_sent;
  int           idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous upper bound: clearing pass, a few full-size solves and many small ones
  initial begin
    #1_000_000_000;
    $display("timeout: words sent %0d, checked %0d", words_sent, words_checked);
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // ---------------- predictor ----------------

  function automatic logic [31:0] key_at(input int unsigned slot);
    return tentative[heap_vertex[slot]];
  endfunction

  function automatic void swap_heap(input int unsigned a, input int unsigned b);
    int unsigned va;
    int unsigned vb;
    va = heap_vertex[a];
    vb = heap_vertex[b];
    heap_index[va] = b;
    heap_index[vb] = a;
    heap_vertex[a] = vb;
    heap_vertex[b] = va;
  endfunction

  // strict compares only, so equal keys keep their current order
  function automatic void bubble_up(input int unsigned slot);
    while (slot != 0 && key_at(slot) < key_at((slot - 1) / 2)) begin
      swap_heap(slot, (slot - 1) / 2);
      slot = (slot - 1) / 2;
    end
  endfunction

  // left child is tried first and wins on equal keys
  function automatic void bubble_down(input int unsigned slot);
    int unsigned l;
    int unsigned r;
    int unsigned m;
    forever begin
      l = 2 * slot + 1;
      r = 2 * slot + 2;
      m = slot;
      if (l < heap_size && key_at(l) < key_at(m)) m = l;
      if (r < heap_size && key_at(r) < key_at(m)) m = r;
      if (m == slot) break;
      swap_heap(m, slot);
      slot = m;
    end
  endfunction

  function automatic void run_dijkstra(input int unsigned src, input int unsigned veh);
    int unsigned  n;
    int unsigned  u;
    int unsigned  tail;
    int unsigned  e;
    int unsigned  t;
    logic [32:0]  sum;
    logic [31:0]  cut;
    n = vertices_used;
    for (int v = 0; v < n; v++) begin
      tentative[v] = mcsp_pkg::INF_DIST;
      heap_vertex[v] = v;
      heap_index[v] = v;
    end
    tentative[src] = '0;
    bubble_up(src);
    heap_size = n;
    while (heap_size != 0) begin
      u = heap_vertex[0];
      tail = heap_vertex[heap_size - 1];
      heap_vertex[0] = tail;
      heap_index[u] = heap_size - 1;
      heap_index[tail] = 0;
      heap_size--;
      bubble_down(0);
      if (tentative[u] == mcsp_pkg::INF_DIST) continue;
      e = list_first[u];
      while (e != 0) begin
        t = link_target[e-1];
        if (t < n && heap_index[t] < heap_size) begin
          sum = {1'b0, tentative[u]} + link_cost[e-1][veh];
          cut = (sum >= {1'b0, mcsp_pkg::INF_DIST}) ? mcsp_pkg::INF_DIST : sum[31:0];
          if (cut < tentative[t]) begin
            tentative[t] = cut;
            route_prev[veh*mcsp_pkg::MAX_VERTICES + t] = 10'(u);
            bubble_up(heap_index[t]);
          end
        end
        e = link_next[e-1];
      end
    end
    for (int v = 0; v < n; v++) route_cost[veh*mcsp_pkg::MAX_VERTICES + v] = tentative[v];
  endfunction

  // expected result of one accepted word, updating the model state
  function automatic path_result_t predict_word(input mcsp_pkg::action_t act,
      input logic [9:0] from, input logic [9:0] to, input logic [1:0] veh,
      input logic [15:0] c [4]);
    path_result_t r;
    int unsigned  e;
    r.status = mcsp_pkg::STAT_OK;
    r.vertex = from;
    r.distance = '0;
    r.predecessor = '0;
    r.reached = 1'b0;
    case (act)
      mcsp_pkg::ACT_ADD: begin
        if (edges_stored >= mcsp_pkg::MAX_EDGES) begin
          r.status = mcsp_pkg::STAT_FULL;
        end else begin
          e = edges_stored;
          link_target[e] = to;
          for (int k = 0; k < 4; k++) link_cost[e][k] = c[k];
          link_next[e] = list_first[from];
          list_first[from] = e + 1;
          edges_stored = e + 1;
        end
      end
      mcsp_pkg::ACT_SOLVE: begin
        if (from >= vertices_used) begin
          r.status = mcsp_pkg::STAT_RANGE;
        end else begin
          run_dijkstra(from, veh);
          r.reached = 1'b1;
        end
      end
      mcsp_pkg::ACT_QUERY: begin
        if (from >= vertices_used) begin
          r.status = mcsp_pkg::STAT_RANGE;
        end else begin
          r.distance = route_cost[veh*mcsp_pkg::MAX_VERTICES + from];
          r.predecessor = route_prev[veh*mcsp_pkg::MAX_VERTICES + from];
          r.reached = (r.distance != mcsp_pkg::INF_DIST);
        end
      end
      default: begin
        for (int v = 0; v < mcsp_pkg::MAX_VERTICES; v++) list_first[v] = 0;
        edges_stored = 0;
      end
    endcase
    return r;
  endfunction

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    path_result_t want;
    if (rst_n && out_valid) begin
      words_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word for vertex %0d", out_vertex));
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("vertex %0d status %0d, want %0d",
                                    want.vertex, out_status, want.status));
        if (out_vertex !== want.vertex)
          report_mismatch($sformatf("vertex %0d, want %0d", out_vertex, want.vertex));
        if (out_distance !== want.distance)
          report_mismatch($sformatf("vertex %0d distance %h, want %h",
                                    want.vertex, out_distance, want.distance));
        if (out_predecessor !== want.predecessor)
          report_mismatch($sformatf("vertex %0d predecessor %0d, want %0d",
                                    want.vertex, out_predecessor, want.predecessor));
        if (out_reached !== want.reached)
          report_mismatch($sformatf("vertex %0d reached %0b, want %0b",
                                    want.vertex, out_reached, want.reached));
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  // drives one word and holds start until it is taken; start stays high, unless a random
  // gap follows, so a following word can go out back to back
  task automatic send_word(input mcsp_pkg::action_t act, input logic [9:0] from,
      input logic [9:0] to = '0, input logic [1:0] veh = '0,
      input logic [15:0] w = '0, input logic [15:0] cr = '0,
      input logic [15:0] bk = '0, input logic [15:0] tr = '0);
    logic [15:0] c [4];
    start <= 1'b1;
    in_action <= act;
    in_from_vertex <= from;
    in_to_vertex <= to;
    in_vehicle <= veh;
    in_walk_cost <= w;
    in_car_cost <= cr;
    in_bike_cost <= bk;
    in_terrain_cost <= tr;
    do @(posedge clk); while (busy);
    c = '{w, cr, bk, tr};
    expected_results.push_back(predict_word(act, from, to, veh, c));
    words_sent++;
    if (act == mcsp_pkg::ACT_SOLVE) solves_sent++;
    // random sender gap, which also lowers start
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // lower start and wait until every expected word is back
  task automatic drain;
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_vertex_count(input logic [10:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_vertex_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertices_used = (value < mcsp_pkg::MAX_VERTICES) ? value : mcsp_pkg::MAX_VERTICES;
  endtask

  task automatic send_edge(input int unsigned from, input int unsigned to);
    send_word(mcsp_pkg::ACT_ADD, 10'(from), 10'(to), 2'd0,
              16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)),
              16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)));
  endtask

  // ---------------- tests ----------------

  // hand-built small graph: zero and maximum costs, ties, unreachable vertices
  task automatic test_directed_graph;
    send_word(mcsp_pkg::ACT_QUERY, 10'd5, '0, 2'd2);   // reset zeros read back as reached
    write_vertex_count(11'd8);
    send_word(mcsp_pkg::ACT_ADD, 10'd0, 10'd1, 2'd0, 16'h0000, 16'hffff, 16'h0100, 16'h0080);
    send_word(mcsp_pkg::ACT_ADD, 10'd1, 10'd2, 2'd0, 16'h0100, 16'h0001, 16'h0100, 16'hffff);
    send_word(mcsp_pkg::ACT_ADD, 10'd0, 10'd2, 2'd0, 16'h0100, 16'hffff, 16'h0200, 16'h0000);
    send_word(mcsp_pkg::ACT_ADD, 10'd2, 10'd3, 2'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_word(mcsp_pkg::ACT_ADD, 10'd3, 10'd9, 2'd0, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    send_word(mcsp_pkg::ACT_ADD, 10'd3, 10'd0, 2'd0, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
    for (int v = 0; v < 4; v++) begin
      send_word(mcsp_pkg::ACT_SOLVE, 10'd0, '0, v[1:0]);
      send_word(mcsp_pkg::ACT_QUERY, 10'd2, '0, v[1:0]);
      send_word(mcsp_pkg::ACT_QUERY, 10'd3, '0, v[1:0]);
    end
    send_word(mcsp_pkg::ACT_SOLVE, 10'd7, '0, 2'd1);     // isolated source
    send_word(mcsp_pkg::ACT_QUERY, 10'd0, '0, 2'd1);     // now unreachable
    send_word(mcsp_pkg::ACT_SOLVE, 10'd8, '0, 2'd0);     // source out of range
    send_word(mcsp_pkg::ACT_QUERY, 10'h3ff, '0, 2'd3);   // query out of range
    send_word(mcsp_pkg::ACT_CLEAR, 10'h2aa);
    send_word(mcsp_pkg::ACT_QUERY, 10'd3, '0, 2'd0);     // results survive a clear
  endtask

  // register extremes: count of zero, one, full size and above full size
  task automatic test_count_extremes;
    write_vertex_count(11'd0);
    send_word(mcsp_pkg::ACT_SOLVE, 10'd0);
    send_word(mcsp_pkg::ACT_QUERY, 10'd0);
    write_vertex_count(11'd1);
    send_word(mcsp_pkg::ACT_ADD, 10'd0, 10'd0, 2'd0, 16'h0010, 16'h0020, 16'h0030, 16'h0040);
    send_word(mcsp_pkg::ACT_SOLVE, 10'd0, '0, 2'd3);
    send_word(mcsp_pkg::ACT_QUERY, 10'd0, '0, 2'd3);
    send_word(mcsp_pkg::ACT_SOLVE, 10'd1);
    write_vertex_count(11'd2047);
    send_edge(1023, 0);
    send_edge(0, 1023);
    send_word(mcsp_pkg::ACT_SOLVE, 10'd1023, '0, 2'd2);
    send_word(mcsp_pkg::ACT_QUERY, 10'd1023, '0, 2'd2);
    send_word(mcsp_pkg::ACT_QUERY, 10'd512, '0, 2'd2);
    write_vertex_count(11'd1024);
    send_word(mcsp_pkg::ACT_SOLVE, 10'($urandom_range(1023)), '0, 2'($urandom_range(3)));
    send_word(mcsp_pkg::ACT_CLEAR, 10'd0);
  endtask

  // many edges on a small graph: parallel edges, self loops, targets past the count
  task automatic test_dense_graph;
    write_vertex_count(11'd16);
    idle_pct = 5;
    for (int i = 0; i < 200; i++) send_edge($urandom_range(17), $urandom_range(17));
    send_edge(3, 4);
    send_edge(1023, 1023);
    send_word(mcsp_pkg::ACT_SOLVE, 10'($urandom_range(15)), '0, 2'($urandom_range(3)));
    for (int v = 0; v < 16; v += 3)
      send_word(mcsp_pkg::ACT_QUERY, v[9:0], '0, 2'($urandom_range(3)));
    send_word(mcsp_pkg::ACT_CLEAR, 10'd0);
    send_edge(2, 5);
  endtask

  // random graphs of small size with adds, solves, queries and an odd clear
  task automatic test_random_graphs(input int pct, input int words);
    int unsigned n;
    int unsigned pick;
    int unsigned from;
    idle_pct = pct;
    for (int i = 0; i < words; i++) begin
      if (i % 90 == 0) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(2, 40);
        write_vertex_count(n[10:0]);
        idle_pct = pct;
        if ($urandom_range(2) == 0)
          send_word(mcsp_pkg::ACT_CLEAR, 10'($urandom_range(1023)));
      end
      pick = $urandom_range(99);
      from = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(n + 1);
      if (pick < 45)
        send_edge(from, ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n + 1));
      else if (pick < 65)
        send_word(mcsp_pkg::ACT_SOLVE, 10'(from), 10'($urandom_range(1023)),
                  2'($urandom_range(3)));
      else if (pick < 99)
        send_word(mcsp_pkg::ACT_QUERY, 10'(from), 10'($urandom_range(1023)),
                  2'($urandom_range(3)));
      else
        send_word(mcsp_pkg::ACT_CLEAR, 10'(from));
    end
  endtask

  // ---------------- main sequence ----------------

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = mcsp_pkg::ACT_ADD;
    in_from_vertex = '0;
    in_to_vertex = '0;
    in_vehicle = '0;
    in_walk_cost = '0;
    in_car_cost = '0;
    in_bike_cost = '0;
    in_terrain_cost = '0;
    cfg_valid = 1'b0;
    cfg_vertex_count = '0;
    err_count = 0;
    words_sent = 0;
    words_checked = 0;
    solves_sent = 0;
    idle_pct = 0;
    vertices_used = mcsp_pkg::MAX_VERTICES;
    edges_stored = 0;
    heap_size = 0;
    for (int v = 0; v < mcsp_pkg::MAX_VERTICES; v++) list_first[v] = 0;
    for (int i = 0; i < 4*mcsp_pkg::MAX_VERTICES; i++) begin
      route_prev[i] = '0;
      route_cost[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_graph();
    test_count_extremes();
    idle_pct = 30;
    test_dense_graph();
    // idle phases: none, sender mostly idle, receiver phase (no effect), both
    test_random_graphs(0, 220);
    test_random_graphs(73, 220);
    test_random_graphs(0, 210);
    test_random_graphs(8, 210);
    drain();

    $display("covered %0d words (%0d solves), %0d results checked, counts 0 to 2047",
             words_sent, solves_sent, words_checked);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
